// ----- rtl/core/crcfc_pkg.sv -----
// ----------------------------------------------------------------------------
// crcfc_pkg
// Shared types, constants and the CRC-32 byte update for the frame checker.
// ----------------------------------------------------------------------------
package crcfc_pkg;

    localparam int HEADER_BYTES = 44;
    localparam int TAG_BYTES    = 32;

    // header byte offsets
    localparam int MAGIC_END = 2;
    localparam int FLAGS_END = 4;
    localparam int LEN_END   = 8;
    localparam int HCRC_BEG  = 40;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam int TDATA_W = 96;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_TAG     = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT_HDR = 3'd1,
        ST_MAGIC_BAD = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_CRC_BAD   = 3'd5,
        ST_TAG_MISS  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        REG_FRAME_MAGIC   = 2'd0,
        REG_MAX_PAYLOAD   = 2'd1,
        REG_TAG_FLAG_MASK = 2'd2,
        REG_TAG_REQUIRED  = 2'd3
    } t_reg_idx;

    // results of one input beat: optional forwarded byte, optional status
    typedef struct packed {
        logic        has_data;
        t_kind       data_kind;
        logic [7:0]  data_byte;
        logic        has_status;
        t_status     status;
        logic [15:0] flags;
        logic [31:0] length;
        logic [31:0] consumed;
    } t_step;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/crcfc_parser.sv -----
// ----------------------------------------------------------------------------
// crcfc_parser
// Header capture, payload CRC and frame sequencing; one byte per beat.
// ----------------------------------------------------------------------------
module crcfc_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_frame_begin,
    input  logic              i_buffer_end,
    output crcfc_pkg::t_step  o_step
);
    import crcfc_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_TAG     = 5'b01000,
        PH_DISCARD = 5'b10000
    } t_phase;

    logic [15:0] r_frame_magic;
    logic [31:0] r_max_payload;
    logic [15:0] r_tag_flag_mask;
    logic        r_tag_required;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [15:0] r_flags, n_flags;
    logic [31:0] r_length, n_length;
    logic [15:0] r_magic, n_magic;
    logic [31:0] r_hcrc, n_hcrc;
    logic [31:0] r_crc, n_crc;

    logic        fresh;
    t_phase      e_phase;
    logic [31:0] e_pos;
    logic [31:0] pos_inc;
    logic        tag_present;
    logic [32:0] cons_pay_w;
    logic [31:0] cons_pay;
    logic [33:0] cons_tag_w;
    logic [31:0] cons_tag;
    t_step       step;

    function automatic t_status final_status(input logic [31:0] crc,
                                             input logic [31:0] hcrc,
                                             input logic        tag_ok,
                                             input logic        tag_req);
        if ((crc ^ CRC_INIT) != hcrc) begin
            return ST_CRC_BAD;
        end
        if (!tag_ok && tag_req) begin
            return ST_TAG_MISS;
        end
        return ST_OK;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_magic   <= '0;
            r_max_payload   <= '0;
            r_tag_flag_mask <= '0;
            r_tag_required  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_FRAME_MAGIC:   r_frame_magic   <= i_cfg_data[15:0];
                REG_MAX_PAYLOAD:   r_max_payload   <= i_cfg_data;
                REG_TAG_FLAG_MASK: r_tag_flag_mask <= i_cfg_data[15:0];
                REG_TAG_REQUIRED:  r_tag_required  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        fresh   = i_frame_begin || (r_phase == PH_IDLE);
        e_phase = fresh ? PH_HEADER : r_phase;
        e_pos   = fresh ? '0 : r_pos;
        pos_inc = e_pos + 32'd1;

        n_phase  = e_phase;
        n_pos    = e_pos;
        n_flags  = fresh ? '0 : r_flags;
        n_length = fresh ? '0 : r_length;
        n_magic  = fresh ? '0 : r_magic;
        n_hcrc   = fresh ? '0 : r_hcrc;
        n_crc    = fresh ? CRC_INIT : r_crc;

        // header words take this byte before any check
        if (e_phase == PH_HEADER) begin
            if (e_pos < 32'(MAGIC_END)) begin
                n_magic = {n_magic[7:0], i_byte};
            end else if (e_pos < 32'(FLAGS_END)) begin
                n_flags = {n_flags[7:0], i_byte};
            end else if (e_pos < 32'(LEN_END)) begin
                n_length = {n_length[23:0], i_byte};
            end else if (e_pos >= 32'(HCRC_BEG)) begin
                n_hcrc = {n_hcrc[23:0], i_byte};
            end
        end
        if (e_phase == PH_PAYLOAD) begin
            n_crc = crc32_byte(n_crc, i_byte);
        end

        tag_present = (n_flags & r_tag_flag_mask) != '0;
        cons_pay_w  = {1'b0, e_pos} + 33'(HEADER_BYTES + 1);
        cons_pay    = cons_pay_w[32] ? '1 : cons_pay_w[31:0];
        cons_tag_w  = {2'b00, n_length} + {2'b00, e_pos} + 34'(HEADER_BYTES + 1);
        cons_tag    = (cons_tag_w[33:32] != 2'b00) ? '1 : cons_tag_w[31:0];

        step            = '0;
        step.flags      = n_flags;
        step.length     = n_length;
        step.data_byte  = i_byte;
        step.data_kind  = (e_phase == PH_TAG) ? KIND_TAG : KIND_PAYLOAD;
        step.has_data   = (e_phase == PH_PAYLOAD) || (e_phase == PH_TAG);

        unique case (e_phase)
            PH_DISCARD: begin
                if (i_buffer_end) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_HEADER: begin
                if (e_pos != 32'(HEADER_BYTES - 1)) begin
                    if (i_buffer_end) begin
                        step.has_status = 1'b1;
                        step.status     = ST_SHORT_HDR;
                        step.consumed   = pos_inc;
                        step.flags      = '0;
                        step.length     = '0;
                        n_phase         = PH_IDLE;
                    end else begin
                        n_pos = pos_inc;
                    end
                end else begin
                    step.has_status = 1'b1;
                    step.consumed   = 32'(HEADER_BYTES);
                    n_pos           = '0;
                    if (n_magic != r_frame_magic) begin
                        step.status = ST_MAGIC_BAD;
                        n_phase     = i_buffer_end ? PH_IDLE : PH_DISCARD;
                    end else if (n_length > r_max_payload) begin
                        step.status = ST_TOO_LARGE;
                        n_phase     = i_buffer_end ? PH_IDLE : PH_DISCARD;
                    end else if (n_length == '0 && !tag_present) begin
                        step.status = final_status(n_crc, n_hcrc, tag_present,
                                                   r_tag_required);
                        n_phase     = PH_IDLE;
                    end else if (i_buffer_end) begin
                        step.status = ST_TRUNCATED;
                        n_phase     = PH_IDLE;
                    end else begin
                        step.has_status = 1'b0;
                        n_phase = (n_length != '0) ? PH_PAYLOAD : PH_TAG;
                    end
                end
            end
            PH_PAYLOAD: begin
                step.consumed = cons_pay;
                if (pos_inc == n_length) begin
                    n_pos = '0;
                    if (!tag_present) begin
                        step.has_status = 1'b1;
                        step.status     = final_status(n_crc, n_hcrc, tag_present,
                                                       r_tag_required);
                        n_phase         = PH_IDLE;
                    end else if (i_buffer_end) begin
                        step.has_status = 1'b1;
                        step.status     = ST_TRUNCATED;
                        n_phase         = PH_IDLE;
                    end else begin
                        n_phase = PH_TAG;
                    end
                end else if (i_buffer_end) begin
                    step.has_status = 1'b1;
                    step.status     = ST_TRUNCATED;
                    n_phase         = PH_IDLE;
                end else begin
                    n_pos = pos_inc;
                end
            end
            PH_TAG: begin
                step.consumed = cons_tag;
                if (pos_inc == 32'(TAG_BYTES)) begin
                    step.has_status = 1'b1;
                    step.status     = final_status(n_crc, n_hcrc, tag_present,
                                                   r_tag_required);
                    n_phase         = PH_IDLE;
                end else if (i_buffer_end) begin
                    step.has_status = 1'b1;
                    step.status     = ST_TRUNCATED;
                    n_phase         = PH_IDLE;
                end else begin
                    n_pos = pos_inc;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pos    <= n_pos;
            r_flags  <= n_flags;
            r_length <= n_length;
            r_magic  <= n_magic;
            r_hcrc   <= n_hcrc;
            r_crc    <= n_crc;
        end
    end

    assign o_step = step;

endmodule

// ----- rtl/core/crcfc_out_queue.sv -----
// ----------------------------------------------------------------------------
// crcfc_out_queue
// Two-entry result buffer; each entry leaves as one or two output beats.
// ----------------------------------------------------------------------------
module crcfc_out_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  crcfc_pkg::t_step                   i_step,
    output logic                               o_full,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [crcfc_pkg::TDATA_W-1:0]      m_axis_tdata,
    output logic [1:0]                         m_axis_tuser,
    output logic                               m_axis_tlast
);
    import crcfc_pkg::*;

    t_step       r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        r_second;

    t_step       head;
    logic        emit_status;
    logic        beat_last;
    logic        pop;
    t_kind       kind;

    always_comb begin
        head        = r_q[r_rd_ptr];
        emit_status = !head.has_data || r_second;
        beat_last   = emit_status || !head.has_status;
        kind        = emit_status ? KIND_STATUS : head.data_kind;
        pop         = m_axis_tvalid && m_axis_tready && beat_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
            r_second <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
            if (m_axis_tvalid && m_axis_tready) begin
                r_second <= !beat_last;
            end
        end
    end

    assign o_full        = (r_count == 2'd2);
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tuser  = kind;
    assign m_axis_tlast  = beat_last;
    assign m_axis_tdata  = {5'd0,
                            emit_status ? head.consumed : 32'd0,
                            emit_status ? head.status : ST_OK,
                            emit_status ? head.length : 32'd0,
                            emit_status ? head.flags : 16'd0,
                            emit_status ? 8'd0 : head.data_byte};

endmodule

// ----- rtl/core/crc_frame_checker.sv -----
// ----------------------------------------------------------------------------
// crc_frame_checker
// Byte-serial frame checker: header parse, payload CRC-32, payload/tag
// forwarding and an end-of-frame status beat.
// Each result is registered in the two-entry result buffer, then offered.
// Throughput: one input byte per cycle while the result buffer is not full;
// a byte yielding data and a status needs two beats on the one-beat port.
// Reset: synchronous, active low; parser returns to idle, registers to zero,
// result buffer empties.
// ----------------------------------------------------------------------------
module crc_frame_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_addr,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // rx_byte
    input  logic                           s_axis_tuser,   // frame_begin
    input  logic                           s_axis_tlast,   // buffer_end
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_byte[7:0], frame_flags[23:8], payload_length[55:24],
    // frame_status[58:56], bytes_consumed[90:59], zero pad
    output logic [crcfc_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                     m_axis_tuser,   // out_kind
    output logic                           m_axis_tlast    // last_of_run
);
    import crcfc_pkg::*;

    logic  accept;
    logic  full;
    t_step step;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    crcfc_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_byte        (s_axis_tdata),
        .i_frame_begin (s_axis_tuser),
        .i_buffer_end  (s_axis_tlast),
        .o_step        (step)
    );

    crcfc_out_queue u_out_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (accept && (step.has_data || step.has_status)),
        .i_step        (step),
        .o_full        (full),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- sim/crc_frame_checker_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_frame_checker_tb
// Feeds framed byte buffers into the frame checker: good frames, bad magic,
// oversized length, short and truncated buffers, CRC and tag faults, noise
// and restarts. A byte-level parser model predicts every output beat, which
// is checked field by field. The register settings cycle through four
// mixes of source gaps and sink backpressure.
// ----------------------------------------------------------------------------
import crcfc_pkg::*;

class frame_parse_tracker;
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_TAG,
        PH_DISCARD
    } parse_phase_t;

    typedef struct {
        t_kind       kind;
        logic [7:0]  data;
        logic [15:0] flags;
        logic [31:0] length;
        t_status     status;
        logic [31:0] consumed;
        logic        last;
    } frame_result_t;

    logic [15:0]   cfg_magic;
    logic [31:0]   cfg_max;
    logic [15:0]   cfg_tag_mask;
    logic          cfg_tag_req;

    parse_phase_t  phase;
    logic [31:0]   byte_pos;
    logic [15:0]   magic_w;
    logic [15:0]   flags_w;
    logic [31:0]   length_w;
    logic [31:0]   hdr_crc;
    logic [31:0]   run_crc;

    frame_result_t pending_results[$];
    int            error_count;
    int            result_count;
    int            status_seen[8];

    function new();
        cfg_magic    = '0;
        cfg_max      = '0;
        cfg_tag_mask = '0;
        cfg_tag_req  = 1'b0;
        error_count  = 0;
        result_count = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        start_frame();
        phase = PH_IDLE;
    endfunction

    function void write_reg(t_reg_idx idx, logic [31:0] value);
        case (idx)
            REG_FRAME_MAGIC:   cfg_magic    = value[15:0];
            REG_MAX_PAYLOAD:   cfg_max      = value;
            REG_TAG_FLAG_MASK: cfg_tag_mask = value[15:0];
            REG_TAG_REQUIRED:  cfg_tag_req  = value[0];
        endcase
    endfunction

    // reflected CRC-32, one input bit at a time
    static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function void start_frame();
        phase    = PH_HEADER;
        byte_pos = '0;
        magic_w  = '0;
        flags_w  = '0;
        length_w = '0;
        hdr_crc  = '0;
        run_crc  = CRC_INIT;
    endfunction

    function bit tag_follows();
        return (flags_w & cfg_tag_mask) != 16'd0;
    endfunction

    function t_status end_verdict();
        if ((run_crc ^ CRC_INIT) != hdr_crc) return ST_CRC_BAD;
        if (!tag_follows() && cfg_tag_req) return ST_TAG_MISS;
        return ST_OK;
    endfunction

    function logic [31:0] saturate(longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function void push_byte(t_kind k, logic [7:0] b);
        frame_result_t r;
        r.kind     = k;
        r.data     = b;
        r.flags    = '0;
        r.length   = '0;
        r.status   = ST_OK;
        r.consumed = '0;
        r.last     = 1'b0;
        pending_results.push_back(r);
    endfunction

    function void push_status(t_status st, logic [31:0] consumed);
        frame_result_t r;
        r.kind     = KIND_STATUS;
        r.data     = '0;
        r.flags    = (st == ST_SHORT_HDR) ? 16'd0 : flags_w;
        r.length   = (st == ST_SHORT_HDR) ? 32'd0 : length_w;
        r.status   = st;
        r.consumed = consumed;
        r.last     = 1'b0;
        pending_results.push_back(r);
    endfunction

    // header fault: stop at once on a buffer end, else drop bytes until one
    function void abort_frame(logic eob);
        if (eob) begin
            phase = PH_IDLE;
        end else begin
            phase = PH_DISCARD;
        end
    endfunction

    function void take_byte(logic [7:0] b, logic fb, logic eob);
        int              n0;
        logic [31:0]     pos;
        longint unsigned done;
        logic [31:0]     cons;
        n0 = pending_results.size();
        if (fb || phase == PH_IDLE) start_frame();
        if (phase == PH_DISCARD) begin
            if (eob) phase = PH_IDLE;
            return;
        end
        case (phase)
            PH_HEADER: begin
                pos = byte_pos;
                if (pos < MAGIC_END) magic_w = {magic_w[7:0], b};
                else if (pos < FLAGS_END) flags_w = {flags_w[7:0], b};
                else if (pos < LEN_END) length_w = {length_w[23:0], b};
                else if (pos >= HCRC_BEG) hdr_crc = {hdr_crc[23:0], b};
                if (pos + 1 < HEADER_BYTES) begin
                    if (eob) begin
                        push_status(ST_SHORT_HDR, pos + 1);
                        phase = PH_IDLE;
                    end else begin
                        byte_pos = pos + 1;
                    end
                end else if (magic_w != cfg_magic) begin
                    push_status(ST_MAGIC_BAD, HEADER_BYTES);
                    abort_frame(eob);
                end else if (length_w > cfg_max) begin
                    push_status(ST_TOO_LARGE, HEADER_BYTES);
                    abort_frame(eob);
                end else if (length_w == 0 && !tag_follows()) begin
                    push_status(end_verdict(), HEADER_BYTES);
                    phase = PH_IDLE;
                end else if (eob) begin
                    push_status(ST_TRUNCATED, HEADER_BYTES);
                    phase = PH_IDLE;
                end else begin
                    if (length_w != 0) begin
                        phase = PH_PAYLOAD;
                    end else begin
                        phase = PH_TAG;
                    end
                    byte_pos = '0;
                end
            end
            PH_PAYLOAD: begin
                done = byte_pos + 64'd1;
                cons = saturate(HEADER_BYTES + done);
                push_byte(KIND_PAYLOAD, b);
                run_crc = crc_step(run_crc, b);
                if (done >= length_w) begin
                    if (!tag_follows()) begin
                        push_status(end_verdict(), cons);
                        phase = PH_IDLE;
                    end else if (eob) begin
                        push_status(ST_TRUNCATED, cons);
                        phase = PH_IDLE;
                    end else begin
                        phase    = PH_TAG;
                        byte_pos = '0;
                    end
                end else if (eob) begin
                    push_status(ST_TRUNCATED, cons);
                    phase = PH_IDLE;
                end else begin
                    byte_pos++;
                end
            end
            PH_TAG: begin
                done = byte_pos + 64'd1;
                cons = saturate(HEADER_BYTES + length_w + done);
                push_byte(KIND_TAG, b);
                if (done >= TAG_BYTES) begin
                    push_status(end_verdict(), cons);
                    phase = PH_IDLE;
                end else if (eob) begin
                    push_status(ST_TRUNCATED, cons);
                    phase = PH_IDLE;
                end else begin
                    byte_pos++;
                end
            end
            default: ;
        endcase
        if (pending_results.size() > n0) begin
            pending_results[pending_results.size() - 1].last = 1'b1;
        end
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            error_count++;
        end
    endfunction

    function void match_result(logic [TDATA_W-1:0] data, logic [1:0] kind, logic last);
        frame_result_t e;
        if (pending_results.size() == 0) begin
            $error("unexpected result beat: kind %0d data %h", kind, data);
            error_count++;
            return;
        end
        e = pending_results.pop_front();
        result_count++;
        if (e.kind == KIND_STATUS) status_seen[e.status]++;
        check_field("out_kind", 32'(e.kind), 32'(kind));
        check_field("out_byte", 32'(e.data), 32'(data[7:0]));
        check_field("frame_flags", 32'(e.flags), 32'(data[23:8]));
        check_field("payload_length", e.length, data[55:24]);
        check_field("frame_status", 32'(e.status), 32'(data[58:56]));
        check_field("bytes_consumed", e.consumed, data[90:59]);
        check_field("last_of_run", 32'(e.last), 32'(last));
    endfunction
endclass

module crc_frame_checker_tb;
    localparam int CLK_PERIOD   = 4;
    localparam int NUM_SETTINGS = 8;
    localparam int PHASE_BEATS  = 60;
    localparam int CYCLE_LIMIT  = 200000;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [1:0]           i_cfg_addr    = '0;
    logic [31:0]          i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // rx_byte
    logic                 s_axis_tuser  = 1'b0; // frame_begin
    logic                 s_axis_tlast  = 1'b0; // buffer_end
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // out_byte, frame_flags, payload_length, frame_status, bytes_consumed
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [1:0]           m_axis_tuser;         // out_kind
    logic                 m_axis_tlast;         // last_of_run

    frame_parse_tracker   tracker;
    int                   beats_sent     = 0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   hold_left      = 0;
    int unsigned          cycle_count    = 0;

    crc_frame_checker DUT (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.match_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(logic [7:0] b, logic fb, logic eob);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= fb;
        s_axis_tlast  <= eob;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_byte(b, fb, eob);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic put_reg(t_reg_idx idx, logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        tracker.write_reg(idx, value);
        @(negedge i_clk);
    endtask

    task automatic program_regs(logic [15:0] magic, logic [31:0] max_len,
                                logic [15:0] mask, logic req);
        put_reg(REG_FRAME_MAGIC, {16'd0, magic});
        put_reg(REG_MAX_PAYLOAD, max_len);
        put_reg(REG_TAG_FLAG_MASK, {16'd0, mask});
        put_reg(REG_TAG_REQUIRED, {31'd0, req});
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_frame();
        logic [7:0]  bytes_q[$];
        logic [7:0]  payload_q[$];
        logic [7:0]  b;
        logic [15:0] magic;
        logic [15:0] flags;
        logic [31:0] length;
        logic [31:0] crc;
        int          scen;
        int          pay_n;
        int          cut;
        int          n;
        bit          with_tag;
        bit          fb_first;
        bit          end_last;
        // 3 bad magic, 4 oversized, 5 bad crc, 6 truncated, 7 short header
        scen  = $urandom_range(0, 9);
        magic = tracker.cfg_magic;
        if (scen == 3) magic ^= 16'($urandom_range(1, 16'hFFFF));
        if (scen == 4 && tracker.cfg_max != 32'hFFFF_FFFF) begin
            length = tracker.cfg_max + 1 + ($urandom % (~tracker.cfg_max));
        end else if (tracker.cfg_max == 32'hFFFF_FFFF && $urandom_range(0, 5) == 0) begin
            length = $urandom;
        end else begin
            length = $urandom_range(0, (tracker.cfg_max < 12) ? tracker.cfg_max : 12);
        end
        pay_n    = (length > 24) ? 24 : length;
        with_tag = (tracker.cfg_tag_mask != 0) && ($urandom_range(0, 2) == 0);
        flags    = 16'($urandom);
        if (with_tag) begin
            if ((flags & tracker.cfg_tag_mask) == 0) begin
                flags |= tracker.cfg_tag_mask & (~tracker.cfg_tag_mask + 16'd1);
            end
        end else begin
            flags &= ~tracker.cfg_tag_mask;
        end
        crc = CRC_INIT;
        for (int i = 0; i < pay_n; i++) begin
            b = 8'($urandom);
            payload_q.push_back(b);
            crc = tracker.crc_step(crc, b);
        end
        crc ^= CRC_INIT;
        if (scen == 5) crc ^= ($urandom | 32'd1);
        bytes_q = '{magic[15:8], magic[7:0], flags[15:8], flags[7:0],
                    length[31:24], length[23:16], length[15:8], length[7:0]};
        for (int i = 0; i < 32; i++) bytes_q.push_back(8'($urandom));
        bytes_q.push_back(crc[31:24]);
        bytes_q.push_back(crc[23:16]);
        bytes_q.push_back(crc[15:8]);
        bytes_q.push_back(crc[7:0]);
        foreach (payload_q[i]) bytes_q.push_back(payload_q[i]);
        if (with_tag) begin
            for (int i = 0; i < TAG_BYTES; i++) bytes_q.push_back(8'($urandom));
        end
        cut = bytes_q.size();
        if (scen == 6 && cut > HEADER_BYTES) cut = $urandom_range(HEADER_BYTES, cut - 1);
        else if (scen == 7) cut = $urandom_range(1, HEADER_BYTES - 1);
        fb_first = $urandom_range(0, 6) != 0;
        if (cut < bytes_q.size()) begin
            end_last = $urandom_range(0, 4) != 0;
        end else begin
            end_last = $urandom_range(0, 3) != 0;
        end
        for (int i = 0; i < cut; i++) begin
            send_byte(bytes_q[i], (i == 0) && fb_first, (i == cut - 1) && end_last);
        end
        if ($urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 4);
            for (int j = 0; j < n; j++) begin
                send_byte(8'($urandom), $urandom_range(0, 5) == 0, j == n - 1);
            end
        end
    endtask

    initial begin
        int          phase_start;
        logic [15:0] mask;
        tracker = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // short buffers, a restart mid-header and a bare buffer end
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hA5, 1'b1, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b1);
        drain();

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            case (ph)
                0: ;
                1: program_regs(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
                2: program_regs(16'h0000, 32'd0, 16'h0000, 1'b1);
                default: begin
                    case ($urandom_range(0, 2))
                        0: mask = 16'd0;
                        1: mask = 16'd1 << $urandom_range(0, 15);
                        default: mask = 16'($urandom);
                    endcase
                    program_regs(16'($urandom),
                                 ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF
                                                              : $urandom_range(0, 30),
                                 mask, 1'($urandom_range(0, 1)));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (ph == 4) begin
                @(posedge i_clk);
                hold_left = 400;
                @(negedge i_clk);
            end
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) send_frame();
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("checked %0d input beats and %0d result beats over %0d register settings",
                 beats_sent, tracker.result_count, NUM_SETTINGS);
        $display("frame endings: ok %0d, short %0d, magic %0d, oversize %0d, %s %0d, %s %0d, %s %0d",
                 tracker.status_seen[ST_OK], tracker.status_seen[ST_SHORT_HDR],
                 tracker.status_seen[ST_MAGIC_BAD], tracker.status_seen[ST_TOO_LARGE],
                 "truncated", tracker.status_seen[ST_TRUNCATED],
                 "crc", tracker.status_seen[ST_CRC_BAD],
                 "tag", tracker.status_seen[ST_TAG_MISS]);
        if (tracker.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ----- crc_frame_checker.f -----
rtl/core/crcfc_pkg.sv
rtl/core/crcfc_parser.sv
rtl/core/crcfc_out_queue.sv
rtl/core/crc_frame_checker.sv
sim/crc_frame_checker_tb.sv
